>>> design/sptc_pkg.sv
// Shared types, constants and helpers of the speed PI torque controller.
package sptc_pkg;

  localparam int unsigned FULL_SPEED_W = 14;
  localparam int unsigned GAIN_W       = 24;
  localparam int unsigned LIMIT_W      = 15;
  localparam int unsigned LEVER_W      = 15;
  localparam int unsigned SPEED_W      = 16;
  localparam int unsigned TORQUE_W     = 16;
  localparam int unsigned ERR_W        = 17;
  localparam int unsigned TARGET_W     = 15;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 24;

  localparam int unsigned MUL_W  = 25;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned GP_W   = ERR_W + GAIN_W;
  localparam int unsigned ACC_W  = GP_W + 1;

  localparam int unsigned RND_W     = 30;
  localparam int unsigned RND_SHIFT = 8;
  localparam int unsigned QUO_W     = RND_W - RND_SHIFT;
  localparam logic [RND_W-1:0] RND_ADD = RND_W'(12800);
  localparam int unsigned DIV_SHIFT = 29;
  localparam int unsigned DIV_MULT_W = 23;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(5368710);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SPEED   = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_INTEG_GAIN   = 3'd2,
    CFG_INTEG_LIMIT  = 3'd3,
    CFG_OUTPUT_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEVER,
    ST_RND,
    ST_DIV,
    ST_ERR,
    ST_IMUL,
    ST_IACC,
    ST_ICLMP,
    ST_OSUM,
    ST_OCLMP,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LEVER,
    OP_RND,
    OP_DIV,
    OP_ERR,
    OP_IMUL,
    OP_IACC,
    OP_ICLMP,
    OP_OSUM,
    OP_OCLMP,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic   load_in;
    logic   clr_integ;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [FULL_SPEED_W-1:0] full_speed;
    logic [GAIN_W-1:0]       prop_gain;
    logic [GAIN_W-1:0]       integ_gain;
    logic [LIMIT_W-1:0]      integ_limit;
    logic [LIMIT_W-1:0]      output_limit;
  } cfg_t;

  function automatic logic signed [ACC_W-1:0] clamp_sym(
    input logic signed [ACC_W-1:0] v,
    input logic signed [ACC_W-1:0] lim
  );
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

>>> design/sptc_cfg_regs.sv
// Configuration register bank of the speed PI torque controller.
module sptc_cfg_regs
  import sptc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FULL_SPEED:   cfg_q.full_speed   <= cfg_data_i[FULL_SPEED_W-1:0];
        CFG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_LIMIT:  cfg_q.integ_limit  <= cfg_data_i[LIMIT_W-1:0];
        CFG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/sptc_ctrl.sv
// Sequencing state machine and output valid control of the torque controller.
module sptc_ctrl
  import sptc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_mode_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '{load_in: 1'b0, clr_integ: 1'b0, op: OP_NONE};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i) begin
            cmd_o.clr_integ = 1'b1;
          end else begin
            cmd_o.load_in = 1'b1;
            state_d       = ST_LEVER;
          end
        end
      end
      ST_LEVER: begin
        cmd_o.op = OP_LEVER;
        state_d  = ST_RND;
      end
      ST_RND: begin
        cmd_o.op = OP_RND;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        state_d  = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.op = OP_ERR;
        state_d  = ST_IMUL;
      end
      ST_IMUL: begin
        cmd_o.op = OP_IMUL;
        state_d  = ST_IACC;
      end
      ST_IACC: begin
        cmd_o.op = OP_IACC;
        state_d  = ST_ICLMP;
      end
      ST_ICLMP: begin
        cmd_o.op = OP_ICLMP;
        state_d  = ST_OSUM;
      end
      ST_OSUM: begin
        cmd_o.op = OP_OSUM;
        state_d  = ST_OCLMP;
      end
      ST_OCLMP: begin
        cmd_o.op = OP_OCLMP;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result valid raised outside the final step");

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_mode_i) |=> state_q == ST_LEVER)
    else $error("run request did not start the sequence");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_mode_i) |=> (state_q == ST_IDLE && !$rose(out_valid_q)))
    else $error("clear request produced work or a result");

endmodule

>>> design/sptc_dp.sv
// Shared multiplier datapath: target, error, integrator and torque.
module sptc_dp
  import sptc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  cfg_t                       cfg_i,
  input  logic [LEVER_W-1:0]         lever_pos_i,
  input  logic                       reverse_i,
  input  logic signed [SPEED_W-1:0]  actual_speed_i,
  output logic signed [TORQUE_W-1:0] torque_request_o,
  output logic                       reverse_led_o
);

  localparam int unsigned INT_W = FRAC_BITS + 16;

  logic [LEVER_W-1:0]         lever_q;
  logic                       rev_q;
  logic signed [SPEED_W-1:0]  speed_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ERR_W-1:0]    err_q, err_d;
  logic signed [INT_W-1:0]    integ_q, integ_d;
  logic signed [TORQUE_W-1:0] torque_q, torque_d;
  logic                       led_q;
  logic                       prod_en, acc_en, err_en, out_en;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic [RND_W-1:0]           rnd_sum;
  logic signed [ERR_W-1:0]    tgt;
  logic signed [ACC_W-1:0]    ilim, olim, half, rounded;

  assign ilim    = $signed(ACC_W'(cfg_i.integ_limit)) <<< FRAC_BITS;
  assign olim    = $signed(ACC_W'(cfg_i.output_limit)) <<< FRAC_BITS;
  assign half    = $signed(ACC_W'(1)) <<< (FRAC_BITS - 1);
  assign rnd_sum = prod_q[RND_W-1:0] + RND_ADD;
  assign tgt     = $signed(ERR_W'(prod_q[DIV_SHIFT+TARGET_W-1:DIV_SHIFT]));
  assign rounded = (acc_q + half) >>> FRAC_BITS;

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    prod_en  = 1'b0;
    acc_en   = 1'b0;
    err_en   = 1'b0;
    out_en   = 1'b0;
    acc_d    = acc_q;
    err_d    = err_q;
    integ_d  = integ_q;
    torque_d = rounded[TORQUE_W-1:0];
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_LEVER: begin
        mul_a   = $signed(MUL_W'(lever_q));
        mul_b   = $signed(MUL_W'(cfg_i.full_speed));
        prod_en = 1'b1;
      end
      OP_RND: begin
        acc_d  = $signed(ACC_W'(rnd_sum[RND_W-1:RND_SHIFT]));
        acc_en = 1'b1;
      end
      OP_DIV: begin
        mul_a   = $signed(MUL_W'(acc_q[QUO_W-1:0]));
        mul_b   = $signed(MUL_W'(DIV_MULT));
        prod_en = 1'b1;
      end
      OP_ERR: begin
        err_d  = (rev_q ? -tgt : tgt) - ERR_W'(speed_q);
        err_en = 1'b1;
      end
      OP_IMUL: begin
        mul_a   = MUL_W'(err_q);
        mul_b   = $signed(MUL_W'(cfg_i.integ_gain));
        prod_en = 1'b1;
      end
      OP_IACC: begin
        acc_d  = ACC_W'(integ_q) + ACC_W'($signed(prod_q[GP_W-1:0]));
        acc_en = 1'b1;
      end
      OP_ICLMP: begin
        integ_d = INT_W'(clamp_sym(acc_q, ilim));
        mul_a   = MUL_W'(err_q);
        mul_b   = $signed(MUL_W'(cfg_i.prop_gain));
        prod_en = 1'b1;
      end
      OP_OSUM: begin
        acc_d  = ACC_W'($signed(prod_q[GP_W-1:0])) + ACC_W'(integ_q);
        acc_en = 1'b1;
      end
      OP_OCLMP: begin
        acc_d  = clamp_sym(acc_q, olim);
        acc_en = 1'b1;
      end
      OP_OUT: begin
        out_en = 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd_i.clr_integ) begin
      integ_d = '0;
    end
    prod_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      lever_q <= lever_pos_i;
      rev_q   <= reverse_i;
      speed_q <= actual_speed_i;
    end
    if (prod_en) begin
      prod_q <= prod_d;
    end
    if (acc_en) begin
      acc_q <= acc_d;
    end
    if (err_en) begin
      err_q <= err_d;
    end
    if (out_en) begin
      torque_q <= torque_d;
      led_q    <= rev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else begin
      integ_q <= integ_d;
    end
  end

  assign torque_request_o = torque_q;
  assign reverse_led_o    = led_q;

endmodule

>>> design/speed_pi_torque_controller_unit.sv
// Top level of the speed PI torque controller.
//
//   channel   direction  tdata (low bit up)                         tuser
//   s_axis    in         lever_pos[14:0] reverse[15] speed[31:16]   mode
//   m_axis    out        torque_request[15:0] reverse_led[16]       -
//   cfg       in         cfg_data_i on cfg_we_i at cfg_idx_i        -
//
// A run request steps through the lever, round, divide, error, integrator
// multiply, accumulate, clamp, output sum, clamp and output steps, and the next
// request is taken only after that; one multiplier is shared by the lever,
// reciprocal-divide and two gain products. A clear request yields no result.
// Reset clears the configuration registers and the integrator at once.
// A result waiting in the output register holds; the next request is still
// accepted and is held in its final step until the output register frees.
module speed_pi_torque_controller_unit
  import sptc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // lever_pos, reverse, actual_speed
  input  logic                   s_axis_tuser,  // mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // torque_request, reverse_led, zero fill
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t                       cfg;
  dp_cmd_t                    cmd;
  logic signed [TORQUE_W-1:0] torque;
  logic                       led;

  sptc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sptc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sptc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .lever_pos_i      (s_axis_tdata[LEVER_W-1:0]),
    .reverse_i        (s_axis_tdata[LEVER_W]),
    .actual_speed_i   ($signed(s_axis_tdata[LEVER_W+SPEED_W:LEVER_W+1])),
    .torque_request_o (torque),
    .reverse_led_o    (led)
  );

  assign m_axis_tdata = {(OUT_TDATA_W-TORQUE_W-1)'(0), led, torque};

endmodule
